@@ hdl/rtra_pkg.sv @@
// Package for the ring two-resource arbiter: beat types and phase codes.
// No dependencies; used by ring_two_resource_arbiter.
`timescale 1ns / 1ps

package rtra_pkg;

	typedef struct packed {
		logic       kind;
		logic [2:0] seat;
	} in_beat_t;

	typedef struct packed {
		logic seat_granted;
		logic left_granted;
		logic right_granted;
		logic seat_waiting;
	} out_beat_t;

	localparam logic       KIND_REQUEST = 1'b0;
	localparam logic       KIND_RELEASE = 1'b1;

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_HUNGRY = 2'd1;
	localparam logic [1:0] PH_SERVED = 2'd2;

	localparam logic [7:0] COUNT_MAX   = 8'd255;
	localparam logic [7:0] LIMIT_RESET = 8'd3;

endpackage

@@ hdl/ring_two_resource_arbiter.sv @@
// Ring two-resource arbiter: seat phase and refusal state in two memories,
// walked by a small sequencer through a single read port. Uses rtra_pkg.
`timescale 1ns / 1ps

//  channel  | signals                       | beat
//  ---------+-------------------------------+---------------------------------
//  in       | in_valid, in_ready, in_data   | kind, seat
//  out      | out_valid, out_ready, out_data| seat/left/right granted, waiting
//  cfg      | cfg_we, cfg_data              | fail_limit, written at once
//
// One input at a time. A request tries its seat; a release writes its seat
// idle, then tries the left and the right neighbour; an out-of-range seat
// goes straight to output. Each try reads left, right and center through the
// single read port, then writes the center on a request, grant or refusal.
// Reset clears the sequencer and the valid bits; entries read as idle/zero
// until written. A result held by out_ready stalls the block before idle.

module ring_two_resource_arbiter #(
	parameter int SEATS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rtra_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rtra_pkg::out_beat_t out_data,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_data
);

	localparam int IW = $clog2(SEATS);
	localparam int AW = (IW > 3) ? IW : 3;
	localparam logic [IW-1:0] SEAT_LAST = IW'(SEATS - 1);
	localparam logic [AW:0]   SEATS_W   = (AW + 1)'(SEATS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REL_WR,
		ST_RD_L,
		ST_RD_R,
		ST_RD_C,
		ST_EVAL,
		ST_OUT
	} state_t;

	state_t               state_q;
	logic [7:0]           limit_q;
	logic                 is_rel_q;
	logic                 second_q;
	logic [IW-1:0]        seat_q;
	logic [IW-1:0]        ctr_q;
	logic [1:0]           lph_q;
	logic                 lpr_q;
	logic [1:0]           rph_q;
	logic                 rpr_q;
	rtra_pkg::out_beat_t  res_q;
	rtra_pkg::out_beat_t  out_q;
	logic                 out_valid_q;
	logic [SEATS-1:0]     ph_vld_q;
	logic [SEATS-1:0]     cp_vld_q;

	logic [1:0]           ph_mem [SEATS];
	logic [8:0]           cp_mem [SEATS];
	logic [1:0]           ph_rd_s1;
	logic [8:0]           cp_rd_s1;
	logic                 ph_vld_s1;
	logic                 cp_vld_s1;

	logic [AW-1:0]        seat_ext;
	logic                 seat_ok;
	logic [IW-1:0]        seat_idx;
	logic [IW-1:0]        ctr_left;
	logic [IW-1:0]        ctr_right;
	logic [IW-1:0]        seat_left;
	logic [IW-1:0]        seat_right;
	logic [IW-1:0]        rd_addr;
	logic                 rd_en;
	logic [IW-1:0]        wr_addr;
	logic                 ph_we;
	logic [1:0]           ph_wd;
	logic                 cp_we;
	logic [8:0]           cp_wd;

	logic [1:0]           ph_rd;
	logic [7:0]           cnt_rd;
	logic                 pr_rd;
	logic [1:0]           c_ph;
	logic                 blocked;
	logic                 hungry;
	logic                 grant;
	logic                 refuse;
	logic [7:0]           cnt_inc;

	assign seat_ext = AW'(in_data.seat);
	assign seat_ok  = {1'b0, seat_ext} < SEATS_W;
	assign seat_idx = seat_ext[IW-1:0];

	assign ctr_left   = (ctr_q == '0) ? SEAT_LAST : ctr_q - 1'b1;
	assign ctr_right  = (ctr_q == SEAT_LAST) ? '0 : ctr_q + 1'b1;
	assign seat_left  = (seat_q == '0) ? SEAT_LAST : seat_q - 1'b1;
	assign seat_right = (seat_q == SEAT_LAST) ? '0 : seat_q + 1'b1;

	assign ph_rd  = ph_vld_s1 ? ph_rd_s1 : rtra_pkg::PH_IDLE;
	assign cnt_rd = cp_vld_s1 ? cp_rd_s1[8:1] : 8'd0;
	assign pr_rd  = cp_vld_s1 ? cp_rd_s1[0] : 1'b0;

	assign c_ph    = is_rel_q ? ph_rd : rtra_pkg::PH_HUNGRY;
	assign blocked = lpr_q | rpr_q;
	assign hungry  = c_ph == rtra_pkg::PH_HUNGRY;
	assign grant   = hungry && !blocked && lph_q != rtra_pkg::PH_SERVED
		&& rph_q != rtra_pkg::PH_SERVED;
	assign refuse  = hungry && !blocked && !grant;
	assign cnt_inc = (cnt_rd == rtra_pkg::COUNT_MAX) ? cnt_rd : cnt_rd + 8'd1;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ctr_q;
		wr_addr = ctr_q;
		ph_we   = 1'b0;
		ph_wd   = rtra_pkg::PH_IDLE;
		cp_we   = 1'b0;
		cp_wd   = '0;
		case (state_q)
			ST_REL_WR: begin
				wr_addr = seat_q;
				ph_we   = 1'b1;
			end
			ST_RD_L: begin
				rd_en   = 1'b1;
				rd_addr = ctr_left;
			end
			ST_RD_R: begin
				rd_en   = 1'b1;
				rd_addr = ctr_right;
			end
			ST_RD_C: begin
				rd_en = 1'b1;
			end
			ST_EVAL: begin
				ph_we = grant || !is_rel_q;
				ph_wd = grant ? rtra_pkg::PH_SERVED : rtra_pkg::PH_HUNGRY;
				cp_we = grant || refuse;
				cp_wd = grant ? 9'd0 : {cnt_inc, pr_rd | (cnt_inc == limit_q)};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ph_we) begin
			ph_mem[wr_addr] <= ph_wd;
		end
		if (cp_we) begin
			cp_mem[wr_addr] <= cp_wd;
		end
		if (rd_en) begin
			ph_rd_s1 <= ph_mem[rd_addr];
			cp_rd_s1 <= cp_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			limit_q     <= rtra_pkg::LIMIT_RESET;
			out_valid_q <= 1'b0;
			ph_vld_q    <= '0;
			cp_vld_q    <= '0;
			ph_vld_s1   <= 1'b0;
			cp_vld_s1   <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (out_valid_q && out_ready && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			if (ph_we) begin
				ph_vld_q[wr_addr] <= 1'b1;
			end
			if (cp_we) begin
				cp_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				ph_vld_s1 <= ph_vld_q[rd_addr];
				cp_vld_s1 <= cp_vld_q[rd_addr];
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						res_q    <= '0;
						is_rel_q <= in_data.kind == rtra_pkg::KIND_RELEASE;
						second_q <= 1'b0;
						seat_q   <= seat_idx;
						if (!seat_ok) begin
							state_q <= ST_OUT;
						end else if (in_data.kind == rtra_pkg::KIND_RELEASE) begin
							state_q <= ST_REL_WR;
						end else begin
							ctr_q   <= seat_idx;
							state_q <= ST_RD_L;
						end
					end
				end
				ST_REL_WR: begin
					ctr_q   <= seat_left;
					state_q <= ST_RD_L;
				end
				ST_RD_L: begin
					state_q <= ST_RD_R;
				end
				ST_RD_R: begin
					lph_q   <= ph_rd;
					lpr_q   <= pr_rd;
					state_q <= ST_RD_C;
				end
				ST_RD_C: begin
					rph_q   <= ph_rd;
					rpr_q   <= pr_rd;
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (!is_rel_q) begin
						res_q.seat_granted <= grant;
						res_q.seat_waiting <= !grant;
						state_q            <= ST_OUT;
					end else if (!second_q) begin
						res_q.left_granted <= grant;
						second_q           <= 1'b1;
						ctr_q              <= seat_right;
						state_q            <= ST_RD_L;
					end else begin
						res_q.right_granted <= grant;
						state_q             <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
